### design/lsrf_pkg.sv
package lsrf_pkg;

   localparam int DEFAULT_MAX_SIDE = 128;
   localparam int SIDE_W = 8;
   localparam int AREA_W = 15;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [SIDE_W-1:0] GRID_SIDE_RESET = 8'd128;

   typedef struct packed {
      logic land;
      logic first_row;
      logic first_col;
      logic last_cell;
   } cell_flags_type;

endpackage

### design/lsrf_front.sv
module lsrf_front
   import lsrf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cell_is_land,
   input  logic                       csr_write_enable,
   input  logic [SIDE_W-1:0]          csr_grid_side,
   input  logic                       queue_full,
   output logic                       push,
   output cell_flags_type             push_flags,
   output logic [$clog2(MAX_SIDE)-1:0] push_row,
   output logic [$clog2(MAX_SIDE)-1:0] push_col
);

   localparam int IDX_W = $clog2(MAX_SIDE);

   logic [SIDE_W-1:0] grid_side_ff, grid_side_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [IDX_W-1:0]  last_idx;
   logic              col_end;
   logic              row_end;

   // The grid in use is clamped to one cell at the low end and to the line buffer at the top.
   always_comb begin
      if (grid_side_ff == '0) begin
         last_idx = '0;
      end else if (int'(grid_side_ff) > MAX_SIDE) begin
         last_idx = IDX_W'(MAX_SIDE - 1);
      end else begin
         last_idx = IDX_W'(grid_side_ff - 8'd1);
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;
   assign col_end   = (col_ff == last_idx);
   assign row_end   = (row_ff == last_idx);

   assign push_row             = row_ff;
   assign push_col             = col_ff;
   assign push_flags.land      = req_cell_is_land;
   assign push_flags.first_row = (row_ff == '0);
   assign push_flags.first_col = (col_ff == '0);
   assign push_flags.last_cell = col_end & row_end;

   always_comb begin
      grid_side_in = grid_side_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (csr_write_enable) begin
         grid_side_in = csr_grid_side;
         row_in       = '0;
         col_in       = '0;
      end else if (push) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= GRID_SIDE_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         grid_side_ff <= grid_side_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

endmodule

### design/lsrf_queue.sv
module lsrf_queue
   import lsrf_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/lsrf_back.sv
module lsrf_back
   import lsrf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic                        queue_empty,
   input  cell_flags_type              pop_flags,
   input  logic [$clog2(MAX_SIDE)-1:0] pop_row,
   input  logic [$clog2(MAX_SIDE)-1:0] pop_col,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [SIDE_W-1:0]           rsp_corner_row,
   output logic [SIDE_W-1:0]           rsp_corner_col,
   output logic [SIDE_W-1:0]           rsp_square_side,
   output logic [AREA_W-1:0]           rsp_square_area
);

   localparam int IDX_W = $clog2(MAX_SIDE);

   logic [SIDE_W-1:0] line_buf [MAX_SIDE];

   logic              cell_valid_ff, cell_valid_in;
   cell_flags_type    cell_flags_ff;
   logic [IDX_W-1:0]  cell_row_ff;
   logic [IDX_W-1:0]  cell_col_ff;
   logic [SIDE_W-1:0] above_ff;

   logic [SIDE_W-1:0] left_ff, left_in;
   logic [SIDE_W-1:0] upleft_ff, upleft_in;
   logic [SIDE_W-1:0] best_side_ff, best_side_in;
   logic [SIDE_W-1:0] best_row_ff, best_row_in;
   logic [SIDE_W-1:0] best_col_ff, best_col_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIDE_W-1:0] rsp_row_ff;
   logic [SIDE_W-1:0] rsp_col_ff;
   logic [SIDE_W-1:0] rsp_side_ff;
   logic [2*SIDE_W-1:0] area_full;

   logic              cell_go;
   logic [SIDE_W-1:0] up;
   logic [SIDE_W-1:0] left;
   logic [SIDE_W-1:0] upleft;
   logic [SIDE_W-1:0] min_lu;
   logic [SIDE_W-1:0] min_all;
   logic [SIDE_W-1:0] size;
   logic [SIDE_W-1:0] cand_side;
   logic [SIDE_W-1:0] cand_row;
   logic [SIDE_W-1:0] cand_col;
   logic              emit;

   // A finished grid waits here only while the result register is still occupied.
   assign cell_go = cell_valid_ff &
                    ~(cell_flags_ff.last_cell & rsp_valid_ff & rsp_stall);
   assign pop     = ~queue_empty & (~cell_valid_ff | cell_go);
   assign emit    = cell_go & cell_flags_ff.last_cell;

   assign up      = cell_flags_ff.first_row ? '0 : above_ff;
   assign left    = cell_flags_ff.first_col ? '0 : left_ff;
   assign upleft  = cell_flags_ff.first_col ? '0 : upleft_ff;
   assign min_lu  = (up < left) ? up : left;
   assign min_all = (min_lu < upleft) ? min_lu : upleft;
   assign size    = cell_flags_ff.land ? min_all + 1'b1 : '0;

   always_comb begin
      cand_side = best_side_ff;
      cand_row  = best_row_ff;
      cand_col  = best_col_ff;
      if (size > best_side_ff) begin
         cand_side = size;
         cand_row  = SIDE_W'(cell_row_ff) + 8'd2 - size;
         cand_col  = SIDE_W'(cell_col_ff) + 8'd2 - size;
      end
   end

   always_comb begin
      cell_valid_in = pop | (cell_valid_ff & ~cell_go);
      left_in       = cell_go ? size : left_ff;
      upleft_in     = cell_go ? up : upleft_ff;
      best_side_in  = best_side_ff;
      best_row_in   = best_row_ff;
      best_col_in   = best_col_ff;
      if (restart || emit) begin
         best_side_in = '0;
         best_row_in  = '0;
         best_col_in  = '0;
      end else if (cell_go) begin
         best_side_in = cand_side;
         best_row_in  = cand_row;
         best_col_in  = cand_col;
      end
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
   end

   // The line buffer forwards a write to a read of the same column in the same cycle.
   always_ff @(posedge clock) begin
      if (cell_go) begin
         line_buf[cell_col_ff] <= size;
      end
      if (pop) begin
         above_ff <= (cell_go && cell_col_ff == pop_col) ? size : line_buf[pop_col];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cell_flags_ff <= pop_flags;
         cell_row_ff   <= pop_row;
         cell_col_ff   <= pop_col;
      end
      left_ff   <= left_in;
      upleft_ff <= upleft_in;
      if (emit) begin
         rsp_row_ff  <= cand_row;
         rsp_col_ff  <= cand_col;
         rsp_side_ff <= cand_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_side_ff  <= '0;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
      end else begin
         cell_valid_ff <= cell_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_side_ff  <= best_side_in;
         best_row_ff   <= best_row_in;
         best_col_ff   <= best_col_in;
      end
   end

   assign area_full       = rsp_side_ff * rsp_side_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_corner_row  = rsp_row_ff;
   assign rsp_corner_col  = rsp_col_ff;
   assign rsp_square_side = rsp_side_ff;
   assign rsp_square_area = area_full[AREA_W-1:0];

endmodule

### design/largest_square_region_finder_unit.sv
// Largest all-land square finder for a square grid streamed in row-major order.
// The request channel carries one grid cell per word: req_cell_is_land is 1 for land.
// The response channel carries one word per grid, taken with the grid's last cell:
// the 1-based top-left corner, the side and the area of the largest all-land square.
// A tie keeps the square found first in row-major order; an all-water grid gives zeros.
// csr_grid_side sets the rows and columns of the grid (0 acts as 1, values above
// MAX_SIDE act as MAX_SIDE); a write restarts the scan at the first cell of a new grid.
// Write it only while no cell is in flight.
// Throughput is one cell per cycle while the receiver does not stall, set by the line
// buffer of the previous row, which the back end reads once and writes once per cell.
// The last cell passes the queue and the cell register before the response register.
// A four-word queue separates the cell counter at the front from the line buffer and
// compare logic at the back. When the receiver stalls, the response register holds its
// word, the back end stops at the next grid's last cell, the queue fills and req_stall
// rises. Reset sets the grid side to 128, empties the queue and the response register
// and starts a new grid; the line buffer needs no clearing because the first row of each
// grid never uses the values it holds.
module largest_square_region_finder_unit
   import lsrf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cell_is_land,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SIDE_W-1:0] rsp_corner_row,
   output logic [SIDE_W-1:0] rsp_corner_col,
   output logic [SIDE_W-1:0] rsp_square_side,
   output logic [AREA_W-1:0] rsp_square_area,
   input  logic              csr_write_enable,
   input  logic [SIDE_W-1:0] csr_grid_side
);

   localparam int IDX_W = $clog2(MAX_SIDE);
   localparam int FLAGS_W = $bits(cell_flags_type);
   localparam int ENTRY_W = FLAGS_W + 2 * IDX_W;

   logic             push;
   cell_flags_type   push_flags;
   logic [IDX_W-1:0] push_row;
   logic [IDX_W-1:0] push_col;
   logic             pop;
   cell_flags_type   pop_flags;
   logic [IDX_W-1:0] pop_row;
   logic [IDX_W-1:0] pop_col;
   logic             queue_full;
   logic             queue_empty;
   logic [ENTRY_W-1:0] push_entry;
   logic [ENTRY_W-1:0] pop_entry;

   assign push_entry = {push_flags, push_row, push_col};
   assign {pop_flags, pop_row, pop_col} = pop_entry;

   lsrf_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cell_is_land (req_cell_is_land),
      .csr_write_enable (csr_write_enable),
      .csr_grid_side    (csr_grid_side),
      .queue_full       (queue_full),
      .push             (push),
      .push_flags       (push_flags),
      .push_row         (push_row),
      .push_col         (push_col)
   );

   lsrf_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   lsrf_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .restart         (csr_write_enable),
      .queue_empty     (queue_empty),
      .pop_flags       (pop_flags),
      .pop_row         (pop_row),
      .pop_col         (pop_col),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_corner_row  (rsp_corner_row),
      .rsp_corner_col  (rsp_corner_col),
      .rsp_square_side (rsp_square_side),
      .rsp_square_area (rsp_square_area)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_square_side == '0 |-> rsp_corner_row == '0 && rsp_corner_col == '0)
      else $error("empty result carries a nonzero corner");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_square_side != '0 |-> rsp_corner_row != '0 && rsp_corner_col != '0)
      else $error("found square has a zero corner");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_empty)
      else $error("back end popped an empty queue");

endmodule
